// ===== hdl/rcfft_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfft_pkg
// Shared constants, codes and twiddle generation for the radix-2 FFT.
// ----------------------------------------------------------------------------
package rcfft_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int SAMPLE_W       = 16;
   localparam int DATA_W         = 28;
   localparam int TW_W           = 17;
   localparam int INDEX_W        = 10;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 4;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_NOFRAME = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG2    = 2'd1;

   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // clamp to [0, 1.0] and round Q2.30 to the nearest Q2.15
   function automatic logic [TW_W-1:0] to_q15(input longint s);
      longint v;
      v = s;
      if (v < 0) v = 0;
      if (v > (64'sd1 <<< 30)) v = 64'sd1 <<< 30;
      return TW_W'((v + 64'sd16384) >>> 15);
   endfunction

   // truncating unsigned quotient by shift and subtract; elaboration only
   function automatic longint unsigned udiv(input longint unsigned n,
                                            input longint unsigned d);
      longint unsigned q, r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = (r << 1) | ((n >> b) & 64'd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // {cos, sin} of angle index j, Taylor series in Q2.30; elaboration only
   function automatic logic [2*TW_W-1:0] trig(input longint unsigned j,
                                              input int unsigned lg_max);
      longint unsigned x, x2, tc, ts, i;
      longint sc, ss;
      x  = (64'd2 * PI_Q30 * j) >> lg_max;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      tc = 64'd1 << 30;
      ts = x;
      sc = longint'(tc);
      ss = longint'(ts);
      for (i = 1; i <= 13; i++) begin
         tc = udiv((tc * x2) >> 30, (2 * i - 1) * (2 * i));
         ts = udiv((ts * x2) >> 30, (2 * i) * (2 * i + 1));
         if (i[0]) begin
            sc = sc - longint'(tc);
            ss = ss - longint'(ts);
         end else begin
            sc = sc + longint'(tc);
            ss = ss + longint'(ts);
         end
      end
      return {to_q15(sc), to_q15(ss)};
   endfunction

   // twiddle ROM entry k: {c, s}
   function automatic logic [2*TW_W-1:0] twiddle(input longint unsigned k,
                                                 input int unsigned lg_max);
      longint unsigned q;
      logic [2*TW_W-1:0] cs;
      logic [TW_W-1:0] c, s;
      q = (64'd1 << lg_max) >> 2;
      if (k <= q) begin
         cs = trig(k, lg_max);
         c  = cs[2*TW_W-1:TW_W];
         s  = cs[TW_W-1:0];
      end else begin
         cs = trig(k - q, lg_max);
         c  = -cs[TW_W-1:0];
         s  = cs[2*TW_W-1:TW_W];
      end
      return {c, s};
   endfunction

endpackage

// ===== hdl/rcfft_bfly.sv =====
// ----------------------------------------------------------------------------
// rcfft_bfly
// Three-stage pipelined radix-2 butterfly: multiply, round, add and (forward only) scale.
// ----------------------------------------------------------------------------
module rcfft_bfly (
   input  logic                                  clock,
   input  logic                                  inverse,
   input  logic signed [rcfft_pkg::DATA_W-1:0]   a_re,
   input  logic signed [rcfft_pkg::DATA_W-1:0]   a_im,
   input  logic signed [rcfft_pkg::DATA_W-1:0]   b_re,
   input  logic signed [rcfft_pkg::DATA_W-1:0]   b_im,
   input  logic signed [rcfft_pkg::TW_W-1:0]     w_c,
   input  logic signed [rcfft_pkg::TW_W-1:0]     w_s,
   output logic signed [rcfft_pkg::DATA_W-1:0]   t_re,
   output logic signed [rcfft_pkg::DATA_W-1:0]   t_im,
   output logic signed [rcfft_pkg::DATA_W-1:0]   u_re,
   output logic signed [rcfft_pkg::DATA_W-1:0]   u_im
);

   localparam int DW = rcfft_pkg::DATA_W;
   localparam int PW = rcfft_pkg::DATA_W + rcfft_pkg::TW_W;
   localparam int ZW = PW + 1 - 15;

   function automatic logic signed [DW-1:0] sat(input logic signed [DW+4:0] v);
      logic signed [DW+4:0] hi, lo;
      hi = (DW+5)'((64'sd1 <<< (DW - 1)) - 1);
      lo = -(DW+5)'(64'sd1 <<< (DW - 1));
      if (v > hi) return hi[DW-1:0];
      if (v < lo) return lo[DW-1:0];
      return v[DW-1:0];
   endfunction

   // finish: sum, optional rounded halving, saturation
   function automatic logic signed [DW-1:0] finish(input logic signed [DW-1:0] a,
                                                   input logic signed [ZW-1:0] z,
                                                   input logic sub, input logic inv);
      logic signed [DW+4:0] s, h;
      s = sub ? ((DW+5)'(a) - (DW+5)'(z)) : ((DW+5)'(a) + (DW+5)'(z));
      h = (s + (DW+5)'(1)) >>> 1;
      return inv ? sat(s) : sat(h);
   endfunction

   logic signed [rcfft_pkg::TW_W-1:0] wi;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [DW-1:0] a1_re_ff, a1_im_ff, a2_re_ff, a2_im_ff;
   logic signed [ZW-1:0] zr_ff, zi_ff;
   logic signed [PW:0]   sum_r, sum_i;
   logic                 inv1_ff, inv2_ff;

   assign wi = inverse ? w_s : -w_s;

   assign sum_r = (PW+1)'(p_rr_ff) - (PW+1)'(p_ii_ff) + (PW+1)'(16384);
   assign sum_i = (PW+1)'(p_ri_ff) + (PW+1)'(p_ir_ff) + (PW+1)'(16384);

   always_ff @(posedge clock) begin
      p_rr_ff  <= PW'(b_re) * PW'(w_c);
      p_ii_ff  <= PW'(b_im) * PW'(wi);
      p_ri_ff  <= PW'(b_re) * PW'(wi);
      p_ir_ff  <= PW'(b_im) * PW'(w_c);
      a1_re_ff <= a_re;
      a1_im_ff <= a_im;
      inv1_ff  <= inverse;

      zr_ff    <= sum_r[PW:15];
      zi_ff    <= sum_i[PW:15];
      a2_re_ff <= a1_re_ff;
      a2_im_ff <= a1_im_ff;
      inv2_ff  <= inv1_ff;

      t_re     <= finish(a2_re_ff, zr_ff, 1'b0, inv2_ff);
      t_im     <= finish(a2_im_ff, zi_ff, 1'b0, inv2_ff);
      u_re     <= finish(a2_re_ff, zr_ff, 1'b1, inv2_ff);
      u_im     <= finish(a2_im_ff, zi_ff, 1'b1, inv2_ff);
   end

endmodule

// ===== hdl/radix2_complex_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 decimation-in-time FFT, 2 to MAX_POINTS points, Q1.15 in.
// ----------------------------------------------------------------------------
// A write beat (req_type 0) stores the next sample; the N-th write of a
// frame starts the transform, during which busy is high. The transform runs
// one butterfly at a time through a single shared butterfly unit: read,
// three pipeline stages, then two writes on the single memory write port.
// A read beat (req_type 1) has its result strobed on rsp_strobe in the
// following cycle; the receiver cannot stall, so it must take every result
// in that cycle. Samples are stored bit-reversed as they arrive, so no
// separate reorder pass runs. Reading with no frame ready returns status 1
// with zero fields. Configuration writes are taken only while busy is low;
// a write to the inverse or log2 register drops any partial load or unread
// frame.
// ----------------------------------------------------------------------------
module radix2_complex_fft #(
   parameter int MAX_POINTS = rcfft_pkg::MAX_POINTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request beats
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_type,
   input  logic signed [rcfft_pkg::SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [rcfft_pkg::SAMPLE_W-1:0]  req_sample_im,
   // result beats
   output logic                                   rsp_strobe,
   output logic signed [rcfft_pkg::DATA_W-1:0]    rsp_bin_re,
   output logic signed [rcfft_pkg::DATA_W-1:0]    rsp_bin_im,
   output logic [rcfft_pkg::INDEX_W-1:0]          rsp_bin_index,
   output logic                                   rsp_last_bin,
   output logic                                   rsp_status,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rcfft_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rcfft_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW  = $clog2(MAX_POINTS);          // address bits
   localparam int CW  = AW + 1;                      // counters reach N
   localparam int LW  = $clog2(AW + 2);              // stage / log2 width
   localparam int DW  = rcfft_pkg::DATA_W;
   localparam int MW  = 2 * DW;
   localparam int TWD = MAX_POINTS / 2;
   localparam int TAW = (AW > 1) ? AW - 1 : 1;
   localparam int XW  = rcfft_pkg::TW_W;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_BF_RD   = 5'b00010,
      ST_BF_WAIT = 5'b00100,
      ST_BF_WA   = 5'b01000,
      ST_BF_WB   = 5'b10000
   } state_type;

   typedef logic [2*XW-1:0] rom_type [TWD];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < TWD; k++) r[k] = rcfft_pkg::twiddle(k, AW);
      return r;
   endfunction

   localparam rom_type TW_ROM = build_rom();

   // ---------------------------------------------------------------- state
   state_type       state_ff, state_in;
   logic            inverse_ff, inverse_in;
   logic [3:0]      log2_ff, log2_in;
   logic [CW-1:0]   wcount_ff, wcount_in;
   logic [CW-1:0]   rcount_ff, rcount_in;
   logic            frame_ff, frame_in;
   logic [AW-1:0]   bf_j_ff, bf_j_in;     // butterfly within stage
   logic [LW-1:0]   stage_ff, stage_in;
   logic [1:0]      wait_ff, wait_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   logic            rsp_status_ff, rsp_status_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [rcfft_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   // ---------------------------------------------------------------- memory
   logic [MW-1:0]   work_mem [MAX_POINTS];
   logic [MW-1:0]   rd0_ff, rd1_ff, wr_data;
   logic [AW-1:0]   rd0_addr, rd1_addr, wr_addr;
   logic            wr_en;
   logic [2*XW-1:0] tw_ff;

   // ---------------------------------------------------------------- derived
   logic [LW-1:0]   lg_eff;
   logic [CW-1:0]   n_pts;
   logic [AW:0]     half_mask_w, ia_w;
   logic [AW-1:0]   half_mask, half_bit, ia, ib, last_j;
   logic [AW-1:0]   tw_k;
   logic [TAW-1:0]  tw_addr;
   logic [AW-1:0]   wr_rev, wr_fwd;
   logic [CW-1:0]   w_base;
   logic [CW+rcfft_pkg::INDEX_W-1:0] idx_ext;
   logic            req_acc, csr_acc;
   logic signed [DW-1:0] t_re, t_im, u_re, u_im;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign req_acc   = start && !busy;
   assign csr_acc   = csr_valid && csr_ready;

   // effective size: 0 acts as 1, large values clip to the memory size
   always_comb begin
      if (log2_ff == 4'd0)
         lg_eff = LW'(1);
      else if (32'(log2_ff) > AW)
         lg_eff = LW'(AW);
      else
         lg_eff = LW'(log2_ff);
   end

   assign n_pts       = CW'(1) << lg_eff;
   assign half_mask_w = ((AW+1)'(1) << stage_ff) - (AW+1)'(1);
   assign half_mask   = half_mask_w[AW-1:0];
   assign half_bit    = half_mask + AW'(1);
   assign ia_w        = ((AW+1)'(bf_j_ff & ~half_mask) << 1) | (AW+1)'(bf_j_ff & half_mask);
   assign ia          = ia_w[AW-1:0];
   assign ib          = ia | half_bit;
   assign last_j      = AW'((n_pts >> 1) - CW'(1));
   assign tw_k        = (bf_j_ff & half_mask) << (LW'(AW - 1) - stage_ff);
   assign tw_addr     = TAW'(tw_k);

   // load address: write count, bit-reversed over the frame size
   assign w_base = (frame_ff || (wcount_ff >= n_pts)) ? '0 : wcount_ff;
   assign wr_fwd = w_base[AW-1:0];
   always_comb begin
      logic [AW-1:0] full_rev;
      for (int b = 0; b < AW; b++) full_rev[b] = wr_fwd[AW-1-b];
      wr_rev = full_rev >> (LW'(AW) - lg_eff);
   end

   assign idx_ext = {{rcfft_pkg::INDEX_W{1'b0}}, rcount_ff};

   // memory port selection
   always_comb begin
      rd0_addr = (state_ff == ST_IDLE) ? rcount_ff[AW-1:0] : ia;
      rd1_addr = ib;
      wr_en    = 1'b0;
      wr_addr  = wr_rev;
      wr_data  = {DW'(req_sample_re), DW'(req_sample_im)};
      case (state_ff)
         ST_IDLE: begin
            wr_en = req_acc && (req_type == rcfft_pkg::REQ_WRITE);
         end
         ST_BF_WA: begin
            wr_en   = 1'b1;
            wr_addr = ia;
            wr_data = {t_re, t_im};
         end
         ST_BF_WB: begin
            wr_en   = 1'b1;
            wr_addr = ib;
            wr_data = {u_re, u_im};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         work_mem[wr_addr] <= wr_data;
      end
      rd0_ff <= work_mem[rd0_addr];
      rd1_ff <= work_mem[rd1_addr];
      tw_ff  <= TW_ROM[tw_addr];
   end

   // shared butterfly; a from port 0, b from port 1
   rcfft_bfly u_bfly (
      .clock   (clock),
      .inverse (inverse_ff),
      .a_re    (rd0_ff[MW-1:DW]),
      .a_im    (rd0_ff[DW-1:0]),
      .b_re    (rd1_ff[MW-1:DW]),
      .b_im    (rd1_ff[DW-1:0]),
      .w_c     (tw_ff[2*XW-1:XW]),
      .w_s     (tw_ff[XW-1:0]),
      .t_re    (t_re),
      .t_im    (t_im),
      .u_re    (u_re),
      .u_im    (u_im)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      inverse_in    = inverse_ff;
      log2_in       = log2_ff;
      wcount_in     = wcount_ff;
      rcount_in     = rcount_ff;
      frame_in      = frame_ff;
      bf_j_in       = bf_j_ff;
      stage_in      = stage_ff;
      wait_in       = wait_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_index_in  = rsp_index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               if (csr_index == rcfft_pkg::CSR_INVERSE) begin
                  inverse_in = csr_wdata[0];
                  wcount_in  = '0;
                  rcount_in  = '0;
                  frame_in   = 1'b0;
               end else if (csr_index == rcfft_pkg::CSR_LOG2) begin
                  log2_in    = csr_wdata;
                  wcount_in  = '0;
                  rcount_in  = '0;
                  frame_in   = 1'b0;
               end
            end
            if (req_acc) begin
               if (req_type == rcfft_pkg::REQ_WRITE) begin
                  frame_in  = 1'b0;
                  rcount_in = '0;
                  if ((w_base + CW'(1)) >= n_pts) begin
                     wcount_in = '0;
                     bf_j_in   = '0;
                     stage_in  = '0;
                     state_in  = ST_BF_RD;
                  end else begin
                     wcount_in = w_base + CW'(1);
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  if (frame_ff && (rcount_ff < n_pts)) begin
                     rsp_status_in = rcfft_pkg::STATUS_OK;
                     rsp_index_in  = idx_ext[rcfft_pkg::INDEX_W-1:0];
                     rsp_last_in   = (rcount_ff == (n_pts - CW'(1)));
                     if ((rcount_ff + CW'(1)) >= n_pts) begin
                        rcount_in = '0;
                        frame_in  = 1'b0;
                     end else begin
                        rcount_in = rcount_ff + CW'(1);
                     end
                  end else begin
                     rsp_status_in = rcfft_pkg::STATUS_NOFRAME;
                     rsp_index_in  = '0;
                     rsp_last_in   = 1'b0;
                  end
               end
            end
         end
         ST_BF_RD: begin
            wait_in  = 2'd2;
            state_in = ST_BF_WAIT;
         end
         ST_BF_WAIT: begin
            wait_in = wait_ff - 2'd1;
            if (wait_ff == 2'd0) state_in = ST_BF_WA;
         end
         ST_BF_WA: begin
            state_in = ST_BF_WB;
         end
         ST_BF_WB: begin
            state_in = ST_BF_RD;
            if (bf_j_ff == last_j) begin
               bf_j_in  = '0;
               stage_in = stage_ff + LW'(1);
               if (stage_ff == (lg_eff - LW'(1))) begin
                  frame_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               bf_j_in = bf_j_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inverse_ff    <= 1'b0;
         log2_ff       <= 4'd10;
         wcount_ff     <= '0;
         rcount_ff     <= '0;
         frame_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inverse_ff    <= inverse_in;
         log2_ff       <= log2_in;
         wcount_ff     <= wcount_in;
         rcount_ff     <= rcount_in;
         frame_ff      <= frame_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bf_j_ff       <= bf_j_in;
      stage_ff      <= stage_in;
      wait_ff       <= wait_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // result beat: bin data comes straight from the read register
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last_bin  = rsp_last_ff;
   assign rsp_bin_index = rsp_index_ff;
   assign rsp_bin_re    = rsp_status_ff ? '0 : rd0_ff[MW-1:DW];
   assign rsp_bin_im    = rsp_status_ff ? '0 : rd0_ff[DW-1:0];

endmodule

// ===== hdl/rcfft_chk.sv =====
// ----------------------------------------------------------------------------
// rcfft_chk
// Port-level checks for the FFT, bound to the top level.
// ----------------------------------------------------------------------------
module rcfft_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_type,
   input logic                                  rsp_strobe,
   input logic signed [rcfft_pkg::DATA_W-1:0]   rsp_bin_re,
   input logic signed [rcfft_pkg::DATA_W-1:0]   rsp_bin_im,
   input logic [rcfft_pkg::INDEX_W-1:0]         rsp_bin_index,
   input logic                                  rsp_last_bin,
   input logic                                  rsp_status
);

   // every read beat gets exactly its result in the next cycle
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == rcfft_pkg::REQ_READ) |=> rsp_strobe)
      else $error("read beat without result");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy && (req_type == rcfft_pkg::REQ_READ)) |=> !rsp_strobe)
      else $error("result without read beat");

   a_noframe_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == rcfft_pkg::STATUS_NOFRAME) |->
         (rsp_bin_re == '0) && (rsp_bin_im == '0) && (rsp_bin_index == '0)
         && !rsp_last_bin)
      else $error("no-frame result carries data");

   // transform only starts after a write beat
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && ($past(req_type) == rcfft_pkg::REQ_WRITE))
      else $error("busy without a write beat");

endmodule

bind radix2_complex_fft rcfft_chk u_rcfft_chk (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_type      (req_type),
   .rsp_strobe    (rsp_strobe),
   .rsp_bin_re    (rsp_bin_re),
   .rsp_bin_im    (rsp_bin_im),
   .rsp_bin_index (rsp_bin_index),
   .rsp_last_bin  (rsp_last_bin),
   .rsp_status    (rsp_status)
);
